// ===== hdl/mdcq_pkg.sv =====
package mdcq_pkg;

   localparam int NUM_BUTTONS_DEF = 3;

   // field widths
   localparam int POS_W     = 16;
   localparam int STAMP_W   = 32;
   localparam int ACT_W     = 9;
   localparam int BTN_W     = 8;
   localparam int MOD_W     = 8;
   localparam int CFG_W     = 16;
   localparam int EN_W      = 3;
   localparam int CSR_IDX_W = 3;
   localparam int TDATA_W   = 96;

   // record kinds
   localparam logic [1:0] KIND_EMPTY = 2'd0;
   localparam logic [1:0] KIND_HELD  = 2'd1;
   localparam logic [1:0] KIND_REL   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DC_TIME  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DC_DELAY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MOVE_TOL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BTN_EN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ALT_MODE = 3'd4;

   localparam logic [CFG_W-1:0] MOVE_TOL_RST = 16'd5;

   // x sits in the lowest bits once packed
   typedef struct packed {
      logic               motion;
      logic [MOD_W-1:0]   mods;
      logic [BTN_W-1:0]   buttons;
      logic [ACT_W-1:0]   action;
      logic [STAMP_W-1:0] stamp;
      logic [POS_W-1:0]   y;
      logic [POS_W-1:0]   x;
   } res_type;

   typedef struct packed {
      logic load;
      logic fl_a;
      logic fl_b;
      logic ev;
      logic emit_ev;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic op;
      logic emit_dn;
      logic emit_up;
      logic eaten;
      logic slot_free;
      logic out_free;
      logic pend_valid;
   } sts_type;

   // one-hot action bit, zero when beyond the action field
   function automatic logic [ACT_W-1:0] act_bit(input int pos);
      logic [ACT_W-1:0] m;
      m = '0;
      for (int k = 0; k < ACT_W; k++) begin
         if (k == pos) m[k] = 1'b1;
      end
      return m;
   endfunction

endpackage

// ===== hdl/mdcq_ctrl.sv =====
module mdcq_ctrl #(
   parameter int NumButtons = mdcq_pkg::NUM_BUTTONS_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           req_tvalid,
   output logic                                           req_tready,
   input  mdcq_pkg::sts_type                              sts,
   output mdcq_pkg::cmd_type                              cmd,
   output logic [(NumButtons > 1 ? $clog2(NumButtons) : 1)-1:0] btn
);
   import mdcq_pkg::*;

   localparam int BtnW = (NumButtons > 1) ? $clog2(NumButtons) : 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_FL_A = 3'd1;
   localparam logic [2:0] S_FL_B = 3'd2;
   localparam logic [2:0] S_EV   = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   logic [2:0]      state_ff, state_in;
   logic [BtnW-1:0] btn_ff, btn_in;
   logic            last_btn;

   assign last_btn   = (btn_ff == BtnW'(NumButtons - 1));
   assign req_tready = (state_ff == S_IDLE);
   assign btn        = btn_ff;

   always_comb begin
      state_in = state_ff;
      btn_in   = btn_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               btn_in   = '0;
               state_in = S_FL_A;
            end
         end
         S_FL_A: begin
            if (!sts.emit_dn || sts.slot_free) begin
               cmd.fl_a = 1'b1;
               state_in = S_FL_B;
            end
         end
         S_FL_B: begin
            if (!sts.emit_up || sts.slot_free) begin
               cmd.fl_b = 1'b1;
               if (!last_btn) begin
                  btn_in   = btn_ff + 1'b1;
                  state_in = S_FL_A;
               end else if (sts.op) begin
                  state_in = S_FIN;
               end else begin
                  btn_in   = '0;
                  state_in = S_EV;
               end
            end
         end
         S_EV: begin
            cmd.ev = 1'b1;
            if (last_btn) begin
               state_in = S_EMIT;
            end else begin
               btn_in = btn_ff + 1'b1;
            end
         end
         S_EMIT: begin
            if (sts.eaten) begin
               state_in = S_FIN;
            end else if (sts.slot_free) begin
               cmd.emit_ev = 1'b1;
               state_in    = S_FIN;
            end
         end
         S_FIN: begin
            if (!sts.pend_valid) begin
               state_in = S_IDLE;
            end else if (sts.out_free) begin
               cmd.fin  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         btn_ff   <= '0;
      end else begin
         state_ff <= state_in;
         btn_ff   <= btn_in;
      end
   end

endmodule

// ===== hdl/mdcq_dp.sv =====
module mdcq_dp #(
   parameter int NumButtons = mdcq_pkg::NUM_BUTTONS_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  mdcq_pkg::cmd_type                              cmd,
   input  logic [(NumButtons > 1 ? $clog2(NumButtons) : 1)-1:0] btn,
   output mdcq_pkg::sts_type                              sts,
   input  logic [mdcq_pkg::TDATA_W-1:0]                   req_tdata,
   input  logic                                           req_tuser,
   input  logic                                           csr_valid,
   output logic                                           csr_ready,
   input  logic [mdcq_pkg::CSR_IDX_W-1:0]                 csr_index,
   input  logic [mdcq_pkg::CFG_W-1:0]                     csr_data,
   output logic                                           rsp_tvalid,
   input  logic                                           rsp_tready,
   output logic [mdcq_pkg::TDATA_W-1:0]                   rsp_tdata,
   output logic                                           rsp_tlast
);
   import mdcq_pkg::*;

   localparam int PadW = TDATA_W - $bits(res_type);

   // configuration
   logic [CFG_W-1:0] dct_ff, dcd_ff, tol_ff;
   logic [EN_W-1:0]  en_ff;
   logic             alt_mode_ff;

   // item under work
   res_type in_rec_ff, in_rec_in;
   logic    in_op_ff, in_op_in;
   logic    in_alt_ff, in_alt_in;
   logic    eaten_ff, eaten_in;

   // per-button records
   logic [1:0] dn_kind_ff [NumButtons];
   logic [1:0] dn_kind_in [NumButtons];
   logic [1:0] up_kind_ff [NumButtons];
   logic [1:0] up_kind_in [NumButtons];
   res_type    dn_rec_ff  [NumButtons];
   res_type    dn_rec_in  [NumButtons];
   res_type    up_rec_ff  [NumButtons];
   res_type    up_rec_in  [NumButtons];

   // flush flags between the two flush steps
   logic rel_ff, rel_in;
   logic clr_ff, clr_in;
   logic emit_up_ff, emit_up_in;

   // one-deep hold-back so that the final result can be marked
   res_type pend_ff, pend_in;
   logic    pend_valid_ff, pend_valid_in;
   res_type out_ff, out_in;
   logic    out_last_ff, out_last_in;
   logic    out_valid_ff, out_valid_in;

   logic [1:0]         cur_dn_kind, cur_up_kind;
   res_type            cur_dn, cur_up;
   logic               en_cur;
   logic [POS_W:0]     dx, dy, adx, ady;
   logic [STAMP_W-1:0] dn_age, up_age;
   logic               moved, delay_ok, time_ok, active, release_now, emit_dn;
   logic [ACT_W-1:0]   m_dn, m_up, m_dbl, act, act_new;
   logic [1:0]         store_kind;
   logic               push;
   res_type            push_data;
   logic               out_free;

   assign csr_ready = 1'b1;
   assign out_free  = !out_valid_ff || rsp_tready;

   always_comb begin
      cur_dn_kind = dn_kind_ff[btn];
      cur_up_kind = up_kind_ff[btn];
      cur_dn      = dn_rec_ff[btn];
      cur_up      = up_rec_ff[btn];
      en_cur      = 1'b0;
      for (int j = 0; j < EN_W; j++) begin
         if (int'(btn) == j) en_cur = en_ff[j];
      end

      dx  = {in_rec_ff.x[POS_W-1], in_rec_ff.x} - {cur_dn.x[POS_W-1], cur_dn.x};
      dy  = {in_rec_ff.y[POS_W-1], in_rec_ff.y} - {cur_dn.y[POS_W-1], cur_dn.y};
      adx = dx[POS_W] ? (~dx + 1'b1) : dx;
      ady = dy[POS_W] ? (~dy + 1'b1) : dy;
      moved = (adx > {1'b0, tol_ff}) || (ady > {1'b0, tol_ff});

      dn_age   = in_rec_ff.stamp - cur_dn.stamp;
      up_age   = in_rec_ff.stamp - cur_up.stamp;
      delay_ok = dn_age >= {{(STAMP_W-CFG_W){1'b0}}, dcd_ff};
      time_ok  = up_age >= {{(STAMP_W-CFG_W){1'b0}}, dct_ff};

      active      = en_cur && (cur_dn_kind != KIND_EMPTY);
      release_now = active && (moved || delay_ok);
      emit_dn     = release_now && (cur_dn_kind != KIND_REL);

      m_dn       = act_bit(int'(btn));
      m_up       = act_bit(NumButtons + int'(btn));
      m_dbl      = act_bit(2 * NumButtons + int'(btn));
      act        = in_rec_ff.action;
      act_new    = act;
      store_kind = in_rec_ff.motion ? KIND_REL : KIND_HELD;

      in_rec_in     = in_rec_ff;
      in_op_in      = in_op_ff;
      in_alt_in     = in_alt_ff;
      eaten_in      = eaten_ff;
      dn_kind_in    = dn_kind_ff;
      up_kind_in    = up_kind_ff;
      dn_rec_in     = dn_rec_ff;
      up_rec_in     = up_rec_ff;
      rel_in        = rel_ff;
      clr_in        = clr_ff;
      emit_up_in    = emit_up_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      push          = 1'b0;
      push_data     = in_rec_ff;

      if (cmd.load) begin
         in_rec_in.x       = req_tdata[15:0];
         in_rec_in.y       = req_tdata[31:16];
         in_rec_in.stamp   = req_tdata[63:32];
         in_rec_in.action  = req_tdata[72:64];
         in_rec_in.buttons = req_tdata[80:73];
         in_rec_in.mods    = req_tdata[88:81];
         in_rec_in.motion  = req_tdata[89];
         in_alt_in         = req_tdata[90];
         in_op_in          = req_tuser;
         eaten_in          = 1'b0;
      end

      if (cmd.fl_a) begin
         if (emit_dn) begin
            push      = 1'b1;
            push_data = cur_dn;
         end
         if (release_now) dn_kind_in[btn] = KIND_REL;
         rel_in     = release_now;
         emit_up_in = release_now && (cur_up_kind == KIND_HELD);
         clr_in     = active && (moved || time_ok) &&
                      ((cur_up_kind != KIND_EMPTY) || release_now);
      end

      if (cmd.fl_b) begin
         if (emit_up_ff) begin
            push      = 1'b1;
            push_data = cur_up;
         end
         if (rel_ff) up_kind_in[btn] = KIND_REL;
         if (clr_ff) begin
            dn_kind_in[btn] = KIND_EMPTY;
            up_kind_in[btn] = KIND_EMPTY;
         end
      end

      if (cmd.ev && en_cur) begin
         if (alt_mode_ff && in_alt_ff && (|(act & m_dn))) begin
            act_new = (act & ~m_dn) | m_dbl;
         end else if (cur_dn_kind != KIND_EMPTY) begin
            if (|(act & m_dn)) begin
               act_new         = (act & ~m_dn) | m_dbl;
               dn_kind_in[btn] = KIND_EMPTY;
               up_kind_in[btn] = KIND_EMPTY;
            end
            if (|(act_new & m_up)) begin
               up_kind_in[btn]        = store_kind;
               up_rec_in[btn]         = in_rec_ff;
               up_rec_in[btn].action  = act_new;
               up_rec_in[btn].motion  = 1'b0;
               eaten_in               = 1'b1;
            end
         end else if (|(act & m_dn)) begin
            dn_kind_in[btn]       = store_kind;
            dn_rec_in[btn]        = in_rec_ff;
            dn_rec_in[btn].motion = 1'b0;
            eaten_in              = 1'b1;
         end
         in_rec_in.action = act_new;
      end

      if (cmd.emit_ev) begin
         push      = 1'b1;
         push_data = in_rec_ff;
      end

      if (push) begin
         if (pend_valid_ff) begin
            out_in       = pend_ff;
            out_last_in  = 1'b0;
            out_valid_in = 1'b1;
         end
         pend_in       = push_data;
         pend_valid_in = 1'b1;
      end

      if (cmd.fin && pend_valid_ff) begin
         out_in        = pend_ff;
         out_last_in   = 1'b1;
         out_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dct_ff      <= '0;
         dcd_ff      <= '0;
         tol_ff      <= MOVE_TOL_RST;
         en_ff       <= '0;
         alt_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_DC_TIME:  dct_ff      <= csr_data;
            REG_DC_DELAY: dcd_ff      <= csr_data;
            REG_MOVE_TOL: tol_ff      <= csr_data;
            REG_BTN_EN:   en_ff       <= csr_data[EN_W-1:0];
            REG_ALT_MODE: alt_mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumButtons; i++) begin
            dn_kind_ff[i] <= KIND_EMPTY;
            up_kind_ff[i] <= KIND_EMPTY;
            dn_rec_ff[i]  <= '0;
            up_rec_ff[i]  <= '0;
         end
         eaten_ff      <= 1'b0;
         rel_ff        <= 1'b0;
         clr_ff        <= 1'b0;
         emit_up_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         dn_kind_ff    <= dn_kind_in;
         up_kind_ff    <= up_kind_in;
         dn_rec_ff     <= dn_rec_in;
         up_rec_ff     <= up_rec_in;
         eaten_ff      <= eaten_in;
         rel_ff        <= rel_in;
         clr_ff        <= clr_in;
         emit_up_ff    <= emit_up_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_rec_ff   <= in_rec_in;
      in_op_ff    <= in_op_in;
      in_alt_ff   <= in_alt_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{PadW{1'b0}}, out_ff};
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      sts            = '0;
      sts.op         = in_op_ff;
      sts.emit_dn    = emit_dn;
      sts.emit_up    = emit_up_ff;
      sts.eaten      = eaten_ff;
      sts.slot_free  = !pend_valid_ff || out_free;
      sts.out_free   = out_free;
      sts.pend_valid = pend_valid_ff;
   end

endmodule

// ===== hdl/mouse_double_click_qualifier.sv =====
// Each item runs through an accept step, a flush sweep (two steps per button) and a finish
// step for a tick; a mouse event adds an event sweep (one step per button) and an event result
// step before the finish. Steps that pass on a result wait while the result path is full.
// Results leave through a one-deep hold-back and an output register; the last one
// of an item reaches rsp at the finish step. Synchronous active-high reset clears
// all held records to empty and restores the register defaults (tolerance 5).
module mouse_double_click_qualifier #(
   parameter int NumButtons = mdcq_pkg::NUM_BUTTONS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // input channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // pos_x[15:0], pos_y[31:16], stamp[63:32], action[72:64], button_state[80:73],
   // modifier_keys[88:81], is_motion[89], alt_held[90], zero above
   input  logic [mdcq_pkg::TDATA_W-1:0]    req_tdata,
   // op: 0 mouse event, 1 flush tick
   input  logic                            req_tuser,
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_x[15:0], out_y[31:16], out_stamp[63:32], out_action[72:64],
   // out_buttons[80:73], out_modifiers[88:81], out_motion[89], zero above
   output logic [mdcq_pkg::TDATA_W-1:0]    rsp_tdata,
   output logic                            rsp_tlast,
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mdcq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mdcq_pkg::CFG_W-1:0]      csr_data
);
   import mdcq_pkg::*;

   localparam int BtnW = (NumButtons > 1) ? $clog2(NumButtons) : 1;

   cmd_type         cmd;
   sts_type         sts;
   logic [BtnW-1:0] btn;

   // sequencer: flush sweep (two steps per button: down, then up and clear),
   // event sweep (one step per button), event result, finish
   mdcq_ctrl #(
      .NumButtons (NumButtons)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd),
      .btn        (btn)
   );

   // records, registers, compare logic and the result hold-back / output stage
   mdcq_dp #(
      .NumButtons (NumButtons)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .btn        (btn),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== hdl/mdcq_checker.sv =====
module mdcq_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [mdcq_pkg::TDATA_W-1:0] rsp_tdata,
   input logic                         rsp_tlast
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // and unchanged
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

   // one item at a time: after a transfer in, the input is closed
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while busy");

   // when idle only the final result of the last item may still wait
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      req_tready && rsp_tvalid |-> rsp_tlast)
      else $error("non-final result pending while idle");

endmodule

bind mouse_double_click_qualifier mdcq_checker u_mdcq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== tb/sv/mouse_double_click_qualifier_test.sv =====
`timescale 1ns / 100ps

module mouse_double_click_qualifier_test;
   import mdcq_pkg::*;

   localparam int NB = NUM_BUTTONS_DEF;

   // op carried on req_tuser
   localparam logic OP_EVENT = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // index beyond the register map, must be ignored
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 3'd7;

   // action bit patterns for the directed part
   localparam logic [ACT_W-1:0] ACT_NONE  = 9'h000;
   localparam logic [ACT_W-1:0] ACT_DOWN0 = 9'h001;
   localparam logic [ACT_W-1:0] ACT_DOWN1 = 9'h002;
   localparam logic [ACT_W-1:0] ACT_DOWN2 = 9'h004;
   localparam logic [ACT_W-1:0] ACT_UP0   = 9'h008;
   localparam logic [ACT_W-1:0] ACT_UP2   = 9'h020;
   localparam logic [ACT_W-1:0] ACT_ALL   = 9'h1FF;

   // room for the longest item without stalls, with margin on top
   localparam int SETTLE_CYCLES = 24;
   // cycles without any transfer before the run is called hung
   localparam int STALL_LIMIT   = 5000;

   typedef struct packed {
      logic               op;
      logic [POS_W-1:0]   x;
      logic [POS_W-1:0]   y;
      logic [STAMP_W-1:0] stamp;
      logic [ACT_W-1:0]   action;
      logic [BTN_W-1:0]   buttons;
      logic [MOD_W-1:0]   mods;
      logic               motion;
      logic               alt;
   } mouse_item_type;

   typedef struct packed {
      logic [POS_W-1:0]   x;
      logic [POS_W-1:0]   y;
      logic [STAMP_W-1:0] stamp;
      logic [ACT_W-1:0]   action;
      logic [BTN_W-1:0]   buttons;
      logic [MOD_W-1:0]   mods;
      logic               motion;
      logic               last;
   } mouse_event_type;

   // ---------------------------------------------------------------------------------------
   // DUT and stimulus signals, the stimulus ones known from time zero
   // ---------------------------------------------------------------------------------------
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [TDATA_W-1:0]    req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [TDATA_W-1:0]    rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CFG_W-1:0]      csr_data   = '0;

   always #5 clock = ~clock;

   mouse_double_click_qualifier u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // ---------------------------------------------------------------------------------------
   // Click predictor: its own copy of the per-button records and of the registers.
   // Position words hold y in the upper half, x in the lower; extra words hold
   // modifiers, buttons and action from the top down.
   // ---------------------------------------------------------------------------------------
   logic [1:0]          dn_kind   [NB];
   logic [31:0]         dn_pos    [NB];
   logic [STAMP_W-1:0]  dn_stamp  [NB];
   logic [24:0]         dn_extra  [NB];
   logic [1:0]          up_kind   [NB];
   logic [31:0]         up_pos    [NB];
   logic [STAMP_W-1:0]  up_stamp  [NB];
   logic [24:0]         up_extra  [NB];

   logic [CFG_W-1:0]    cfg_time;
   logic [CFG_W-1:0]    cfg_delay;
   logic [CFG_W-1:0]    cfg_tol;
   logic [EN_W-1:0]     cfg_en;
   logic                cfg_alt;

   mouse_event_type     expected_events[$];
   int                  mismatch_count = 0;

   // idling, in percent of cycles
   int                  send_idle_pct = 19;
   int                  recv_idle_pct = 52;

   // running time and pointer for the random traffic
   logic [STAMP_W-1:0]  now_ticks;
   logic [POS_W-1:0]    ptr_x;
   logic [POS_W-1:0]    ptr_y;
   int                  items_sent;

   function automatic void clear_click_records();
      for (int i = 0; i < NB; i++) begin
         dn_kind[i]  = KIND_EMPTY;
         dn_pos[i]   = '0;
         dn_stamp[i] = '0;
         dn_extra[i] = '0;
         up_kind[i]  = KIND_EMPTY;
         up_pos[i]   = '0;
         up_stamp[i] = '0;
         up_extra[i] = '0;
      end
      cfg_time  = '0;
      cfg_delay = '0;
      cfg_tol   = MOVE_TOL_RST;
      cfg_en    = '0;
      cfg_alt   = 1'b0;
   endfunction

   function automatic void apply_register(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
         REG_DC_TIME:  cfg_time  = val;
         REG_DC_DELAY: cfg_delay = val;
         REG_MOVE_TOL: cfg_tol   = val;
         REG_BTN_EN:   cfg_en    = val[EN_W-1:0];
         REG_ALT_MODE: cfg_alt   = val[0];
         default: ;
      endcase
   endfunction

   function automatic void push_event(logic [31:0] posw, logic [STAMP_W-1:0] stamp,
                                      logic [24:0] extra, logic motion);
      mouse_event_type e;
      e.x       = posw[15:0];
      e.y       = posw[31:16];
      e.stamp   = stamp;
      e.action  = extra[8:0];
      e.buttons = extra[16:9];
      e.mods    = extra[24:17];
      e.motion  = motion;
      e.last    = 1'b0;
      expected_events.push_back(e);
   endfunction

   // release held records whose delay has run out or whose pointer has wandered off,
   // then drop pairs whose double-click window has closed or whose pointer has wandered off
   function automatic void release_due_clicks(logic [STAMP_W-1:0] stamp, logic [31:0] posw);
      int          px;
      int          py;
      int          dx;
      int          dy;
      int          tol;
      logic        moved;
      logic [31:0] age;
      px  = int'($signed(posw[15:0]));
      py  = int'($signed(posw[31:16]));
      tol = int'(cfg_tol);
      for (int i = 0; i < NB; i++) begin
         if (!cfg_en[i] || dn_kind[i] == KIND_EMPTY) continue;
         dx = px - int'($signed(dn_pos[i][15:0]));
         dy = py - int'($signed(dn_pos[i][31:16]));
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         moved = (dx > tol) || (dy > tol);
         age   = stamp - dn_stamp[i];
         if (moved || age >= 32'(cfg_delay)) begin
            if (dn_kind[i] != KIND_REL) begin
               push_event(dn_pos[i], dn_stamp[i], dn_extra[i], 1'b0);
               dn_kind[i] = KIND_REL;
            end
            if (up_kind[i] != KIND_REL) begin
               // an up that was never stored is only marked, not sent
               if (up_kind[i] == KIND_HELD) push_event(up_pos[i], up_stamp[i], up_extra[i], 1'b0);
               up_kind[i] = KIND_REL;
            end
         end
         age = stamp - up_stamp[i];
         if (up_kind[i] != KIND_EMPTY && (moved || age >= 32'(cfg_time))) begin
            dn_kind[i] = KIND_EMPTY;
            up_kind[i] = KIND_EMPTY;
         end
      end
   endfunction

   function automatic void qualify_event(mouse_item_type it);
      logic [31:0]      posw;
      logic [ACT_W-1:0] act;
      logic [ACT_W-1:0] dn;
      logic [ACT_W-1:0] upb;
      logic [ACT_W-1:0] dbl;
      logic [1:0]       store_kind;
      logic             eaten;
      int               first;
      mouse_event_type  tail;
      first = expected_events.size();
      posw  = {it.y, it.x};
      release_due_clicks(it.stamp, posw);
      if (it.op == OP_EVENT) begin
         act        = it.action;
         eaten      = 1'b0;
         // motion-only records are kept as already released, never sent
         store_kind = it.motion ? KIND_REL : KIND_HELD;
         for (int i = 0; i < NB; i++) begin
            dn  = 9'b1 << i;
            upb = 9'b1 << (NB + i);
            dbl = 9'b1 << (2 * NB + i);
            if (!cfg_en[i]) continue;
            if (cfg_alt && it.alt && (act & dn) != '0) begin
               act = (act & ~dn) | dbl;
               continue;
            end
            if (dn_kind[i] != KIND_EMPTY) begin
               if ((act & dn) != '0) begin
                  act        = (act & ~dn) | dbl;
                  dn_kind[i] = KIND_EMPTY;
                  up_kind[i] = KIND_EMPTY;
               end
               if ((act & upb) != '0) begin
                  up_kind[i]  = store_kind;
                  up_pos[i]   = posw;
                  up_stamp[i] = it.stamp;
                  up_extra[i] = {it.mods, it.buttons, act};
                  eaten       = 1'b1;
               end
            end else if ((act & dn) != '0) begin
               dn_kind[i]  = store_kind;
               dn_pos[i]   = posw;
               dn_stamp[i] = it.stamp;
               dn_extra[i] = {it.mods, it.buttons, act};
               eaten       = 1'b1;
            end
         end
         if (!eaten) push_event(posw, it.stamp, {it.mods, it.buttons, act}, it.motion);
      end
      if (expected_events.size() > first) begin
         tail      = expected_events.pop_back();
         tail.last = 1'b1;
         expected_events.push_back(tail);
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Result checking: every transfer on rsp is held against the oldest expectation
   // ---------------------------------------------------------------------------------------
   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      mouse_event_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_events.size() == 0) begin
            $error("result with nothing expected: tdata 'h%0h tlast %b", rsp_tdata, rsp_tlast);
            mismatch_count++;
         end else begin
            want = expected_events.pop_front();
            check_field("out_x",         32'(want.x),       32'(rsp_tdata[15:0]));
            check_field("out_y",         32'(want.y),       32'(rsp_tdata[31:16]));
            check_field("out_stamp",     want.stamp,        rsp_tdata[63:32]);
            check_field("out_action",    32'(want.action),  32'(rsp_tdata[72:64]));
            check_field("out_buttons",   32'(want.buttons), 32'(rsp_tdata[80:73]));
            check_field("out_modifiers", 32'(want.mods),    32'(rsp_tdata[88:81]));
            check_field("out_motion",    32'(want.motion),  32'(rsp_tdata[89]));
            check_field("last",          32'(want.last),    32'(rsp_tlast));
         end
      end
   end

   // receiver stalls at random, new decision each falling edge
   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // watchdog: any transfer on any channel resets the count
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("mouse_double_click_qualifier: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Driving tasks: each is entered and left at a falling edge. req_tvalid is left high
   // after a transfer so that back-to-back items need no second assignment in one step.
   // ---------------------------------------------------------------------------------------
   task automatic send_item(mouse_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tdata  <= {5'b0, it.alt, it.motion, it.mods, it.buttons, it.action,
                     it.stamp, it.y, it.x};
      do @(posedge clock); while (!req_tready);
      qualify_event(it);
      @(negedge clock);
   endtask

   // sender holds off until every expected result is in, then lets the block settle
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_events.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_settings(logic [CFG_W-1:0] dc_time, logic [CFG_W-1:0] dc_delay,
                                logic [CFG_W-1:0] tol, logic [CFG_W-1:0] en,
                                logic [CFG_W-1:0] alt_mode);
      drain_results();
      write_register(REG_DC_TIME,  dc_time);
      write_register(REG_DC_DELAY, dc_delay);
      write_register(REG_MOVE_TOL, tol);
      write_register(REG_BTN_EN,   en);
      write_register(REG_ALT_MODE, alt_mode);
   endtask

   function automatic mouse_item_type mouse_item(logic op, logic [POS_W-1:0] x,
                                                 logic [POS_W-1:0] y,
                                                 logic [STAMP_W-1:0] stamp,
                                                 logic [ACT_W-1:0] action,
                                                 logic [BTN_W-1:0] buttons,
                                                 logic [MOD_W-1:0] mods,
                                                 logic motion, logic alt);
      mouse_item_type it;
      it.op      = op;
      it.x       = x;
      it.y       = y;
      it.stamp   = stamp;
      it.action  = action;
      it.buttons = buttons;
      it.mods    = mods;
      it.motion  = motion;
      it.alt     = alt;
      return it;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Random traffic: mostly click bursts near the running pointer and time, with ticks
   // in between; the rest is unconstrained noise
   // ---------------------------------------------------------------------------------------
   task automatic send_near(logic op, logic [ACT_W-1:0] action);
      mouse_item_type it;
      now_ticks += ($urandom_range(3) == 0) ? $urandom_range(60) : $urandom_range(8);
      if ($urandom_range(5) == 0) begin
         // big enough to break most tolerances
         ptr_x += 16'($urandom_range(24)) - 16'd12;
         ptr_y += 16'($urandom_range(24)) - 16'd12;
      end else begin
         ptr_x += 16'($urandom_range(4)) - 16'd2;
         ptr_y += 16'($urandom_range(4)) - 16'd2;
      end
      it = mouse_item(op, ptr_x, ptr_y, now_ticks, action, 8'($urandom), 8'($urandom),
                      $urandom_range(9) == 0, $urandom_range(3) == 0);
      send_item(it);
      items_sent++;
   endtask

   task automatic send_click_burst();
      int               b;
      logic [ACT_W-1:0] dn;
      logic [ACT_W-1:0] up;
      logic [ACT_W-1:0] stray;
      b     = $urandom_range(NB - 1);
      dn    = 9'b1 << b;
      up    = 9'b1 << (NB + b);
      stray = ($urandom_range(7) == 0) ? 9'($urandom) : ACT_NONE;
      send_near(OP_EVENT, dn | stray);
      if ($urandom_range(4) != 0) send_near(OP_EVENT, up);
      if ($urandom_range(9) < 4) begin
         send_near(OP_EVENT, dn);
         if ($urandom_range(1) == 0) send_near(OP_EVENT, up);
      end
      repeat ($urandom_range(2)) send_near(OP_TICK, 9'($urandom));
   endtask

   task automatic send_noise();
      mouse_item_type it;
      it = mouse_item(1'($urandom_range(1)), 16'($urandom), 16'($urandom), $urandom,
                      9'($urandom), 8'($urandom), 8'($urandom), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
      // sometimes let the noise drag the running clock along, wrap included
      if ($urandom_range(1) == 0) now_ticks = it.stamp;
      send_item(it);
      items_sent++;
   endtask

   task automatic run_random_phase(int send_pct, int recv_pct, logic [CFG_W-1:0] dc_time,
                                   logic [CFG_W-1:0] dc_delay, logic [CFG_W-1:0] tol,
                                   logic [CFG_W-1:0] en, logic [CFG_W-1:0] alt_mode,
                                   int count);
      int r;
      load_settings(dc_time, dc_delay, tol, en, alt_mode);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      items_sent    = 0;
      now_ticks     = $urandom;
      ptr_x         = 16'($urandom);
      ptr_y         = 16'($urandom);
      while (items_sent < count) begin
         r = $urandom_range(99);
         if (r < 60) send_click_burst();
         else if (r < 85) send_near(OP_TICK, 9'($urandom));
         else send_noise();
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // out of reset no button is enabled: events pass straight through, ticks give nothing
   task automatic test_register_defaults();
      send_item(mouse_item(OP_EVENT, 16'h7FFF, 16'h8000, 32'hFFFF_FFFF, ACT_ALL,
                           8'hFF, 8'hFF, 1'b1, 1'b1));
      send_item(mouse_item(OP_TICK, 16'h0000, 16'h0000, 32'h0, ACT_ALL, 8'hFF, 8'hFF,
                           1'b1, 1'b1));
      send_item(mouse_item(OP_EVENT, 16'h8000, 16'h7FFF, 32'h0, ACT_NONE, 8'h00, 8'h00,
                           1'b0, 1'b0));
   endtask

   task automatic test_click_sequences();
      // enable written wide on purpose, only the low bits count
      load_settings(16'd20, 16'd10, 16'd5, 16'hFFFF, 16'd0);
      write_register(REG_SPARE, 16'hFFFF);

      // down, up, down within the window: a double-click
      send_item(mouse_item(OP_EVENT, 16'd10, 16'd10, 32'd100, ACT_DOWN0, 8'h01, 8'h00, 1'b0, 1'b0));
      send_item(mouse_item(OP_EVENT, 16'd10, 16'd10, 32'd102, ACT_UP0,   8'h00, 8'h00, 1'b0, 1'b0));
      send_item(mouse_item(OP_EVENT, 16'd10, 16'd10, 32'd104, ACT_DOWN0, 8'h01, 8'h02, 1'b0, 1'b0));

      // lone down released by a tick after the delay; its up was never stored
      send_item(mouse_item(OP_EVENT, 16'd10, 16'd10, 32'd200, ACT_DOWN1, 8'h02, 8'h00, 1'b0, 1'b0));
      send_item(mouse_item(OP_TICK,  16'd10, 16'd10, 32'd215, ACT_NONE,  8'h00, 8'h00, 1'b0, 1'b0));

      // pointer moves just past the tolerance: down and up go out at once
      send_item(mouse_item(OP_EVENT, 16'd0, 16'd0, 32'd300, ACT_DOWN2, 8'h04, 8'h00, 1'b0, 1'b0));
      send_item(mouse_item(OP_EVENT, 16'd0, 16'd0, 32'd302, ACT_UP2,   8'h00, 8'h00, 1'b0, 1'b0));
      send_item(mouse_item(OP_TICK,  16'd6, 16'd0, 32'd303, ACT_NONE,  8'h00, 8'h00, 1'b0, 1'b0));

      // down from a motion-only event: stored as released, never seen
      send_item(mouse_item(OP_EVENT, 16'd20, 16'd20, 32'd400, ACT_DOWN0, 8'h01, 8'h00, 1'b1, 1'b0));
      send_item(mouse_item(OP_TICK,  16'd20, 16'd20, 32'd420, ACT_NONE,  8'h00, 8'h00, 1'b0, 1'b0));

      // down and up in one event on a held down: double, then the up is held alone
      send_item(mouse_item(OP_EVENT, 16'd30, 16'd30, 32'd500, ACT_DOWN0, 8'h01, 8'h00, 1'b0, 1'b0));
      send_item(mouse_item(OP_EVENT, 16'd30, 16'd30, 32'd501, ACT_DOWN0 | ACT_UP0, 8'h00, 8'h00,
                           1'b0, 1'b0));
      send_item(mouse_item(OP_EVENT, 16'd30, 16'd30, 32'd503, ACT_DOWN0, 8'h01, 8'h00, 1'b0, 1'b0));
      send_item(mouse_item(OP_TICK,  16'd30, 16'd30, 32'd520, ACT_NONE,  8'h00, 8'h00, 1'b0, 1'b0));

      // two buttons down in one event, both released by one tick
      send_item(mouse_item(OP_EVENT, 16'd40, 16'd40, 32'd600, ACT_DOWN0 | ACT_DOWN1, 8'h03, 8'h10,
                           1'b0, 1'b0));
      send_item(mouse_item(OP_TICK,  16'd40, 16'd40, 32'd611, ACT_NONE, 8'h00, 8'h00, 1'b0, 1'b0));

      // alt mode: a down with alt held is a double-click straight away
      drain_results();
      write_register(REG_ALT_MODE, 16'd1);
      send_item(mouse_item(OP_EVENT, 16'd50, 16'd50, 32'd700, ACT_DOWN2, 8'h04, 8'h08, 1'b0, 1'b1));

      // delay measured across the wrap of the time stamp, pointer at the corners
      send_item(mouse_item(OP_EVENT, 16'h8000, 16'h7FFF, 32'hFFFF_FFFA, ACT_DOWN0, 8'h01, 8'h00,
                           1'b0, 1'b0));
      send_item(mouse_item(OP_TICK,  16'h8000, 16'h7FFF, 32'h0000_0004, ACT_NONE, 8'h00, 8'h00,
                           1'b0, 1'b0));
   endtask

   // idling profiles change every two settings; extremes of the time, delay and tolerance registers included
   task automatic test_random_traffic();
      run_random_phase(19, 52, 16'd20,    16'd10,    16'd5,     16'd7, 16'd0, 65);
      run_random_phase(19, 52, 16'd0,     16'd0,     16'd0,     16'd7, 16'd1, 65);
      run_random_phase(52, 19, 16'hFFFF,  16'hFFFF,  16'hFFFF,  16'd5, 16'd0, 65);
      run_random_phase(52, 19, 16'd8,     16'd30,    16'd2,     16'd6, 16'd1, 65);
      run_random_phase(0,  0,  16'd40,    16'd5,     16'd12,    16'd7, 16'd0, 65);
      run_random_phase(0,  0,  16'd15,    16'd15,    16'd5,     16'd3, 16'd1, 65);
   endtask

   // ---------------------------------------------------------------------------------------
   // Sequence: reset once, then the tests in turn, then drain and report
   // ---------------------------------------------------------------------------------------
   initial begin
      clear_click_records();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_defaults();
      test_click_sequences();
      test_random_traffic();

      drain_results();
      if (mismatch_count == 0) begin
         $display("mouse_double_click_qualifier: match");
      end else begin
         $display("mouse_double_click_qualifier: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/mdcq_pkg.sv
hdl/mdcq_ctrl.sv
hdl/mdcq_dp.sv
hdl/mouse_double_click_qualifier.sv
hdl/mdcq_checker.sv
tb/sv/mouse_double_click_qualifier_test.sv
